FILE: rtl/rmp_pkg.sv
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared types and codes for the recursive mutex pool: request and result
// payloads, operation and status codes, controller command and status groups.
// ----------------------------------------------------------------------------
package rmp_pkg;

  // Fixed field widths of the request and result payloads
  localparam int IDX_W   = 9;
  localparam int REQ_ID_W = 16;
  localparam int DEPTH_W = 16;

  // Free-map search groups: 2**GRP_BITS pool entries per group
  localparam int GRP_BITS = 4;
  localparam int GRP_SIZE = 1 << GRP_BITS;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  // Operation codes
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_TRY   = 2'd2;
  localparam logic [1:0] KIND_REL   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_IGN  = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  typedef struct packed {
    logic [1:0]          kind;
    logic [IDX_W-1:0]    lock_index;
    logic                recursive_req;
    logic [REQ_ID_W-1:0] requester_id;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   granted_index;
    logic               used_fallback;
    logic [DEPTH_W-1:0] depth;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch the request
    logic look;    // register the free-group search
    logic addr;    // register the entry address, start the table read
    logic exec;    // update the entry and load the result
    logic clr;     // write one zero entry of the clearing pass
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // clearing pass is at its last entry
    logic out_free;  // result register can take a new result
  } dp_sts_t;

endpackage

FILE: rtl/recursive_mutex_pool.sv
// ----------------------------------------------------------------------------
// recursive_mutex_pool
// Table of recursive mutexes with an allocatable pool and a shared fallback.
// ----------------------------------------------------------------------------
// Each request passes from transfer in to result through the free-group search
// over the allocation map, then the registering of the entry address with a
// read of the entry table through its registered read port, and last the
// read-modify-write of the entry into the table and the result register. The
// controller then returns to idle, in which the next request is transferred,
// so a new request is taken only after the previous one has left its update
// step. The block works on one request at a time and returns exactly one
// result per request. A finished result waits in an output register while the
// next request is taken, and that request holds in its update step until the
// result register frees up. After reset a clearing pass writes every table
// entry, during which in_ready stays low.
module recursive_mutex_pool #(
  parameter int NUM_LOCKS = 256,
  parameter int ID_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rmp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rmp_pkg::out_t out_data
);

  import rmp_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  rmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rmp_dpath #(
    .NUM_LOCKS (NUM_LOCKS),
    .ID_BITS   (ID_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/rmp_ram.sv
// ----------------------------------------------------------------------------
// rmp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rmp_ctrl.sv
// ----------------------------------------------------------------------------
// rmp_ctrl
// Sequencer for the mutex pool: clearing pass after reset, then one request
// at a time through search, table read and entry update.
// ----------------------------------------------------------------------------
module rmp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output rmp_pkg::ctl_cmd_t cmd,
  input  rmp_pkg::dp_sts_t  sts
);

  import rmp_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_ADDR  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive commands
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.clr    = (state_r == S_CLEAR);
  assign cmd.look   = (state_r == S_LOOK);
  assign cmd.addr   = (state_r == S_ADDR);
  assign cmd.exec   = (state_r == S_EXEC) && sts.out_free;

endmodule

FILE: rtl/rmp_dpath.sv
// ----------------------------------------------------------------------------
// rmp_dpath
// Datapath of the mutex pool: request register, allocation map with a
// two-step free search, entry table, entry update logic and result register.
// ----------------------------------------------------------------------------
module rmp_dpath #(
  parameter int NUM_LOCKS = 256,
  parameter int ID_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rmp_pkg::ctl_cmd_t cmd,
  output rmp_pkg::dp_sts_t  sts,
  input  rmp_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rmp_pkg::out_t     out_data
);

  import rmp_pkg::*;

  localparam int IW       = $clog2(NUM_LOCKS + 1);
  localparam int PW       = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int OW       = (ID_BITS < REQ_ID_W) ? ID_BITS : REQ_ID_W;
  localparam int GROUPS   = (NUM_LOCKS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GW       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int GROUPS_P = 1 << GW;
  localparam int MAP_W    = GROUPS_P * GRP_SIZE;
  localparam int CMP_W    = (IW > IDX_W) ? IW : IDX_W;

  typedef struct packed {
    logic               set_up;
    logic               is_rec;
    logic               held;
    logic [OW-1:0]      owner;
    logic [DEPTH_W-1:0] depth;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // Registers
  in_t                 req_r;
  logic [GW-1:0]       grp_r, grp_nxt;
  logic                any_r, any_nxt;
  logic [IW-1:0]       e_r;
  logic [NUM_LOCKS-1:0] in_use_r, in_use_nxt;
  logic [IW-1:0]       clr_cnt_r;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_r;

  // Table port signals
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;

  // Search and request decode
  logic [MAP_W-1:0]    pool_map;
  logic [GRP_SIZE-1:0] grp_word;
  logic [GRP_BITS-1:0] bit_sel;
  logic [IW-1:0]       alloc_e;
  logic [IW-1:0]       target;
  logic [CMP_W-1:0]    idx_ext;
  logic                oor;
  logic [OW-1:0]       req_id;
  logic                is_fb;
  logic [PW-1:0]       pidx;

  // Entry update
  entry_t              rd, cur, nw, setup_ent;
  out_t                res;
  logic                ent_we, use_set, use_clr, owner_hit;

  // Pad the allocation map; entries past the pool read as taken
  always_comb begin
    pool_map = '1;
    pool_map[NUM_LOCKS-1:0] = in_use_r;
  end

  // First group with a free entry (lowest wins)
  always_comb begin
    grp_nxt = '0;
    any_nxt = 1'b0;
    for (int g = GROUPS_P - 1; g >= 0; g--) begin
      if (!(&pool_map[g*GRP_SIZE +: GRP_SIZE])) begin
        grp_nxt = GW'(g);
        any_nxt = 1'b1;
      end
    end
  end

  // First free entry inside the registered group
  assign grp_word = pool_map[{grp_r, {GRP_BITS{1'b0}}} +: GRP_SIZE];

  always_comb begin
    bit_sel = '0;
    for (int b = GRP_SIZE - 1; b >= 0; b--) begin
      if (!grp_word[b]) bit_sel = GRP_BITS'(b);
    end
  end

  assign alloc_e = any_r ? IW'({grp_r, bit_sel}) : IW'(NUM_LOCKS);

  // Decode the held request
  assign idx_ext = CMP_W'(req_r.lock_index);
  assign oor     = (idx_ext > CMP_W'(NUM_LOCKS));
  assign req_id  = req_r.requester_id[OW-1:0];
  assign target  = (req_r.kind == KIND_ALLOC) ? alloc_e :
                   (oor ? '0 : idx_ext[IW-1:0]);
  assign is_fb   = (e_r == IW'(NUM_LOCKS));
  assign pidx    = e_r[PW-1:0];

  // Keep reading the held entry while the update waits
  assign ram_raddr = cmd.addr ? target : e_r;

  rmp_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_LOCKS + 1)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  always_comb begin
    setup_ent        = '0;
    setup_ent.set_up = 1'b1;
    setup_ent.is_rec = req_r.recursive_req;
  end

  // Compute the new entry and the result
  always_comb begin
    cur       = rd;
    nw        = rd;
    res       = '0;
    ent_we    = 1'b0;
    use_set   = 1'b0;
    use_clr   = 1'b0;
    owner_hit = 1'b0;
    unique case (req_r.kind)
      KIND_ALLOC: begin
        res.granted_index = IDX_W'(e_r);
        if (!is_fb) begin
          nw      = setup_ent;
          ent_we  = 1'b1;
          use_set = 1'b1;
        end else begin
          res.used_fallback = 1'b1;
          if (!rd.set_up) begin
            nw     = setup_ent;
            ent_we = 1'b1;
          end
        end
        res.depth = nw.depth;
      end
      KIND_CLOSE: begin
        if (oor) begin
          res.status = ST_IGN;
        end else if (!is_fb) begin
          nw.set_up = 1'b0;
          ent_we    = 1'b1;
          use_clr   = 1'b1;
        end else begin
          res.status = ST_IGN;
          res.depth  = rd.depth;
        end
      end
      KIND_TRY: begin
        if (oor) begin
          res.status = ST_IGN;
        end else begin
          // Set up on first use
          cur       = rd.set_up ? rd : setup_ent;
          nw        = cur;
          owner_hit = cur.held && (cur.owner == req_id);
          if (cur.is_rec && owner_hit) begin
            if (cur.depth == DEPTH_MAX) begin
              res.status = ST_SAT;
            end else begin
              nw.depth = cur.depth + 1'b1;
            end
          end else if (cur.held) begin
            res.status = ST_BUSY;
          end else begin
            nw.held  = 1'b1;
            nw.owner = req_id;
            nw.depth = DEPTH_W'(1);
          end
          ent_we    = 1'b1;
          res.depth = nw.depth;
        end
      end
      KIND_REL: begin
        if (oor) begin
          res.status = ST_IGN;
        end else begin
          owner_hit = rd.held && (rd.owner == req_id);
          if (!owner_hit) begin
            res.status = ST_IGN;
          end else if (rd.is_rec && (rd.depth > DEPTH_W'(1))) begin
            nw.depth = rd.depth - 1'b1;
          end else begin
            nw.held  = 1'b0;
            nw.owner = '0;
            nw.depth = '0;
          end
          ent_we    = 1'b1;
          res.depth = nw.depth;
        end
      end
    endcase
  end

  // Table write: clearing pass or entry update
  assign ram_we    = cmd.clr || (cmd.exec && ent_we);
  assign ram_waddr = cmd.clr ? clr_cnt_r : e_r;
  assign ram_wdata = cmd.clr ? '0 : EW'(nw);

  // Allocation map update
  always_comb begin
    in_use_nxt = in_use_r;
    if (cmd.exec && use_set) in_use_nxt[pidx] = 1'b1;
    if (cmd.exec && use_clr) in_use_nxt[pidx] = 1'b0;
  end

  // Hold the result until transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) req_r <= in_data;
    if (cmd.look) begin
      grp_r <= grp_nxt;
      any_r <= any_nxt;
    end
    if (cmd.addr) e_r <= target;
    if (cmd.exec) out_r <= res;
  end

  assign sts.clr_last = (clr_cnt_r == IW'(NUM_LOCKS));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/rmp_checker.sv
// ----------------------------------------------------------------------------
// rmp_checker
// Port-level checks for the recursive mutex pool, bound to the top level.
// ----------------------------------------------------------------------------
module rmp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input rmp_pkg::out_t out_data
);

  import rmp_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One request in flight: no transfer in right after a transfer in
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // Fallback allocation always completes
  a_fb_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.used_fallback |-> out_data.status == ST_DONE)
    else $error("fallback allocation with non-done status");

  // Busy means the lock is held at some depth
  a_busy_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_BUSY |-> out_data.depth != '0)
    else $error("busy reported with zero depth");

  // Saturation only at the depth ceiling
  a_sat_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_SAT |-> out_data.depth == DEPTH_MAX)
    else $error("saturation reported below the depth ceiling");

endmodule

bind recursive_mutex_pool rmp_checker u_rmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the recursive mutex pool. A queue of lock requests
// feeds a bursty valid/ready driver; every accepted request runs through a
// local copy of the mutex table to produce the expected result. A monitor
// compares each result transfer against the oldest expectation. The stimulus
// covers the directed corner cases, random lock traffic and a pool fill into
// the fallback entry.
// ----------------------------------------------------------------------------
module tb;
  import rmp_pkg::*;

  localparam int NUM_LOCKS      = 256;
  localparam int ID_BITS        = 16;
  localparam int ENTRIES        = NUM_LOCKS + 1;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int HOLDOFF_AT     = 40;
  localparam int LONG_HOLDOFF   = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [IDX_W-1:0] FALLBACK_IDX = IDX_W'(NUM_LOCKS);

  typedef enum {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_PULSE} sink_mode_e;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Lock table as seen by the bench
  bit                 pool_taken  [NUM_LOCKS];
  bit                 entry_ready [ENTRIES];
  bit                 entry_rec   [ENTRIES];
  bit                 entry_held  [ENTRIES];
  bit [REQ_ID_W-1:0]  entry_owner [ENTRIES];
  bit [DEPTH_W-1:0]   entry_depth [ENTRIES];

  in_t        pending_reqs[$];
  out_t       expected_results[$];
  int         err_cnt      = 0;
  int         results_seen = 0;
  int         idle_cycles  = 0;
  int         burst_left   = 0;
  int         gap_left     = 0;
  int         holdoff_left = 0;
  bit         holdoff_done = 1'b0;
  int         phase_left   = 0;
  sink_mode_e sink_mode    = SINK_OPEN;

  recursive_mutex_pool #(
    .NUM_LOCKS(NUM_LOCKS),
    .ID_BITS  (ID_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Set an entry up fresh: free, depth zero, recursion mode from the request
  function automatic void init_entry(int slot, bit rec);
    entry_ready[slot] = 1'b1;
    entry_held[slot]  = 1'b0;
    entry_owner[slot] = '0;
    entry_depth[slot] = '0;
    entry_rec[slot]   = rec;
  endfunction

  // Apply one lock request to the table and return the result it produces
  function automatic out_t apply_lock_op(in_t req);
    out_t res;
    int   slot;
    bit   owned;
    res = '0;
    if (req.kind == KIND_ALLOC) begin
      // take the lowest free pool entry, else the shared fallback
      slot = NUM_LOCKS;
      for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
        if (!pool_taken[i]) slot = i;
      end
      if (slot < NUM_LOCKS) begin
        pool_taken[slot] = 1'b1;
        init_entry(slot, req.recursive_req);
      end else begin
        res.used_fallback = 1'b1;
        if (!entry_ready[slot]) init_entry(slot, req.recursive_req);
      end
      res.granted_index = IDX_W'(slot);
      res.depth         = entry_depth[slot];
    end else if (req.lock_index > FALLBACK_IDX) begin
      res.status = ST_IGN;
    end else begin
      slot  = int'(req.lock_index);
      owned = entry_held[slot] && (entry_owner[slot] == req.requester_id);
      case (req.kind)
        KIND_CLOSE: begin
          // closing a pool entry keeps the hold state for the old owner
          if (slot < NUM_LOCKS) begin
            pool_taken[slot]  = 1'b0;
            entry_ready[slot] = 1'b0;
          end else begin
            res.status = ST_IGN;
            res.depth  = entry_depth[slot];
          end
        end
        KIND_TRY: begin
          if (!entry_ready[slot]) begin
            init_entry(slot, req.recursive_req);
            owned = 1'b0;
          end
          if (entry_rec[slot] && owned) begin
            if (entry_depth[slot] == DEPTH_MAX) begin
              res.status = ST_SAT;
            end else begin
              entry_depth[slot]++;
            end
          end else if (entry_held[slot]) begin
            res.status = ST_BUSY;
          end else begin
            entry_held[slot]  = 1'b1;
            entry_owner[slot] = req.requester_id;
            entry_depth[slot] = DEPTH_W'(1);
          end
          res.depth = entry_depth[slot];
        end
        default: begin
          if (!owned) begin
            res.status = ST_IGN;
          end else if (entry_rec[slot] && entry_depth[slot] > 1) begin
            entry_depth[slot]--;
          end else begin
            entry_held[slot]  = 1'b0;
            entry_owner[slot] = '0;
            entry_depth[slot] = '0;
          end
          res.depth = entry_depth[slot];
        end
      endcase
    end
    return res;
  endfunction

  task automatic add_req(logic [1:0] kind, logic [IDX_W-1:0] idx, bit rec,
                         logic [REQ_ID_W-1:0] id);
    in_t req;
    req.kind          = kind;
    req.lock_index    = idx;
    req.recursive_req = rec;
    req.requester_id  = id;
    pending_reqs.push_back(req);
  endtask

  // Mostly a handful of hot entries, so owners meet each other often
  function automatic logic [IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return IDX_W'($urandom_range(0, 7));
    if (r < 15) return FALLBACK_IDX;
    if (r < 18) return IDX_W'($urandom_range(0, NUM_LOCKS - 1));
    return IDX_W'($urandom_range(NUM_LOCKS + 1, (1 << IDX_W) - 1));
  endfunction

  function automatic logic [REQ_ID_W-1:0] pick_id();
    case ($urandom_range(0, 3))
      0:       return 16'h0001;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      default: return REQ_ID_W'($urandom_range(1, (1 << REQ_ID_W) - 1));
    endcase
  endfunction

  task automatic check_field(string name, logic [DEPTH_W-1:0] exp_val,
                             logic [DEPTH_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
               act_val);
      err_cnt++;
    end
  endtask

  // Request driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin : req_driver
    bit send_now;
    send_now = in_valid;
    if (!rst_n) begin
      send_now = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_lock_op(in_data));
        send_now = 1'b0;
      end
      if (!send_now) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          in_data  <= pending_reqs.pop_front();
          send_now = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_valid <= send_now;
  end

  // Result sink: stall patterns that change phase by phase, plus one long hold-off
  always @(posedge clk) begin : result_sink
    bit take;
    take = 1'b1;
    if (holdoff_left != 0) begin
      holdoff_left--;
      take = 1'b0;
    end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
      // hold off long enough for the block to back up and stall its input
      holdoff_done = 1'b1;
      holdoff_left = LONG_HOLDOFF;
      take         = 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 64);
        sink_mode  = sink_mode_e'($urandom_range(0, 3));
      end else begin
        phase_left--;
      end
      case (sink_mode)
        SINK_OPEN:   take = 1'b1;
        SINK_HALF:   take = 1'($urandom_range(0, 1));
        SINK_SPARSE: take = ($urandom_range(0, 3) == 0);
        default:     take = ((phase_left % 4) < 2);
      endcase
    end
    out_ready <= take;
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    out_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        err_cnt++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("status", DEPTH_W'(exp_res.status), DEPTH_W'(out_data.status));
        check_field("granted_index", DEPTH_W'(exp_res.granted_index),
                    DEPTH_W'(out_data.granted_index));
        check_field("used_fallback", DEPTH_W'(exp_res.used_fallback),
                    DEPTH_W'(out_data.used_fallback));
        check_field("depth", exp_res.depth, out_data.depth);
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int                  n_random;
    int                  runs;
    bit                  pool_filled;
    logic [IDX_W-1:0]    idx;
    logic [REQ_ID_W-1:0] id;
    bit                  rec;

    // Directed: nesting, busy, foreign release, close with a live holder,
    // out-of-range indices, fallback use and allocation order
    add_req(KIND_TRY,   9'd0,          1'b1, 16'h0001);
    add_req(KIND_TRY,   9'd0,          1'b0, 16'h0001);
    add_req(KIND_TRY,   9'd0,          1'b0, 16'hFFFF);
    add_req(KIND_REL,   9'd0,          1'b0, 16'hFFFF);
    add_req(KIND_REL,   9'd0,          1'b0, 16'h0001);
    add_req(KIND_REL,   9'd0,          1'b0, 16'h0001);
    add_req(KIND_REL,   9'd0,          1'b0, 16'h0001);
    add_req(KIND_TRY,   9'd1,          1'b0, 16'hFFFF);
    add_req(KIND_TRY,   9'd1,          1'b1, 16'hFFFF);
    add_req(KIND_CLOSE, 9'd1,          1'b0, 16'h0002);
    add_req(KIND_REL,   9'd1,          1'b0, 16'hFFFF);
    add_req(KIND_CLOSE, FALLBACK_IDX,  1'b0, 16'h0002);
    add_req(KIND_TRY,   9'h101,        1'b1, 16'h0003);
    add_req(KIND_REL,   9'h1FF,        1'b0, 16'h0003);
    add_req(KIND_CLOSE, 9'h155,        1'b1, 16'h0003);
    add_req(KIND_ALLOC, 9'h1FF,        1'b1, 16'h5A5A);
    add_req(KIND_ALLOC, 9'd0,          1'b0, 16'hA5A5);
    add_req(KIND_TRY,   FALLBACK_IDX,  1'b1, 16'h00A5);
    add_req(KIND_TRY,   FALLBACK_IDX,  1'b0, 16'h00A5);
    add_req(KIND_CLOSE, FALLBACK_IDX,  1'b0, 16'h00A5);
    add_req(KIND_REL,   FALLBACK_IDX,  1'b0, 16'h00A5);
    add_req(KIND_REL,   FALLBACK_IDX,  1'b0, 16'h00A5);
    add_req(KIND_CLOSE, 9'd0,          1'b0, 16'h0001);
    add_req(KIND_ALLOC, 9'd200,        1'b1, 16'h0001);
    add_req(KIND_CLOSE, 9'd200,        1'b0, 16'h0001);

    // Random traffic: nested acquire/release runs, single ops, one pool fill
    n_random    = 0;
    pool_filled = 1'b0;
    while (n_random < RANDOM_ITEMS) begin
      if (!pool_filled && n_random >= 500) begin
        // fill the pool and spill into the fallback, then free every pool entry
        for (int i = 0; i < NUM_LOCKS + 3; i++) begin
          add_req(KIND_ALLOC, IDX_W'($urandom()), 1'($urandom_range(0, 1)), pick_id());
        end
        add_req(KIND_TRY, FALLBACK_IDX, 1'($urandom_range(0, 1)), 16'h0001);
        add_req(KIND_REL, FALLBACK_IDX, 1'($urandom_range(0, 1)), 16'h0001);
        for (int i = 0; i < NUM_LOCKS; i++) begin
          add_req(KIND_CLOSE, IDX_W'(i), 1'($urandom_range(0, 1)), pick_id());
        end
        n_random    += 2 * NUM_LOCKS + 5;
        pool_filled = 1'b1;
      end else if ($urandom_range(0, 9) < 6) begin
        // nested hold by one owner with foreign requests mixed in
        idx  = pick_index();
        id   = pick_id();
        rec  = $urandom_range(0, 3) != 0;
        runs = $urandom_range(1, 5);
        for (int i = 0; i < runs; i++) begin
          add_req(KIND_TRY, idx, rec, id);
          if ($urandom_range(0, 3) == 0) begin
            add_req($urandom_range(0, 1) ? KIND_TRY : KIND_REL, idx,
                    1'($urandom_range(0, 1)), pick_id());
            n_random++;
          end
        end
        for (int i = 0; i < runs; i++) begin
          add_req(KIND_REL, idx, 1'($urandom_range(0, 1)), id);
        end
        if ($urandom_range(0, 7) == 0) begin
          add_req(KIND_CLOSE, idx, 1'($urandom_range(0, 1)), id);
          n_random++;
        end
        n_random += 2 * runs;
      end else begin
        add_req(2'($urandom_range(0, 3)), pick_index(), 1'($urandom_range(0, 1)),
                pick_id());
        n_random++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go out and every result to come back
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
